>>> design/cpv_pkg.sv
package cpv_pkg;

   localparam int unsigned CRC_W        = 32;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned COUNT_W      = 11;
   localparam int unsigned HEADER_BYTES = 4;

   localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;

   // page_kind codes
   localparam logic KIND_FULL    = 1'b0;
   localparam logic KIND_PARTIAL = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_section;
   } byte_item_type;

   // Reflected CRC update over one byte, bit by bit (LSB first).
   function automatic logic [CRC_W-1:0] crc_byte_update(
      input logic [CRC_W-1:0]  crc,
      input logic [BYTE_W-1:0] data,
      input logic [CRC_W-1:0]  poly
   );
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> design/cpv_if.sv
interface cpv_req_if import cpv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_section;

   modport source (output valid, data_byte, end_of_section, input ready);
   modport sink   (input valid, data_byte, end_of_section, output ready);
   modport monitor (input valid, ready, data_byte, end_of_section);
endinterface

interface cpv_rsp_if import cpv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CRC_W-1:0]   page_number;
   logic               page_kind;
   logic [CRC_W-1:0]   stored_crc;
   logic [CRC_W-1:0]   computed_crc;
   logic               crc_ok;
   logic [COUNT_W-1:0] page_bytes;

   modport source (output valid, page_number, page_kind, stored_crc, computed_crc,
                   crc_ok, page_bytes, input ready);
   modport sink   (input valid, page_number, page_kind, stored_crc, computed_crc,
                   crc_ok, page_bytes, output ready);
   modport monitor (input valid, ready, page_number, page_kind, stored_crc,
                    computed_crc, crc_ok, page_bytes);
endinterface

interface cpv_csr_if import cpv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] crc_polynomial;

   modport source (output valid, crc_polynomial, input ready);
   modport sink   (input valid, crc_polynomial, output ready);
   modport monitor (input valid, ready, crc_polynomial);
endinterface

>>> design/cpv_input_stage.sv
module cpv_input_stage import cpv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   cpv_req_if.sink       req_chan,
   input  logic          take,
   output logic          item_valid,
   output byte_item_type item
);

   logic          valid_ff, valid_in;
   byte_item_type item_ff,  item_in;
   logic          load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in               = 1'b1;
         item_in.data_byte      = req_chan.data_byte;
         item_in.end_of_section = req_chan.end_of_section;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/cpv_page_engine.sv
module cpv_page_engine import cpv_pkg::*; #(
   parameter int unsigned PAGE_BYTES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  byte_item_type    item,
   input  logic [CRC_W-1:0] poly,
   output logic             take,
   cpv_rsp_if.source        rsp_chan
);

   localparam int unsigned        POS_W      = $clog2(PAGE_BYTES);
   localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(PAGE_BYTES - 1);
   localparam logic [COUNT_W-1:0] FULL_BYTES = COUNT_W'(PAGE_BYTES);

   logic [CRC_W-1:0]   crc_ff,     crc_in;
   logic [POS_W-1:0]   pos_ff,     pos_in;
   logic [CRC_W-1:0]   captured_ff, captured_in;
   logic [CRC_W-1:0]   page_ff,    page_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]   r_page_ff,  r_page_in;
   logic               r_kind_ff,  r_kind_in;
   logic [CRC_W-1:0]   r_stored_ff, r_stored_in;
   logic [CRC_W-1:0]   r_calc_ff,  r_calc_in;
   logic               r_ok_ff,    r_ok_in;
   logic [COUNT_W-1:0] r_bytes_ff, r_bytes_in;

   logic               in_header;
   logic               page_full;
   logic [POS_W:0]     taken;
   logic [CRC_W-1:0]   crc_next;
   logic [CRC_W-1:0]   captured_next;
   logic [CRC_W-1:0]   computed;

   assign take = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign in_header = (pos_ff[POS_W-1:2] == '0);
   assign page_full = (pos_ff == LAST_POS);
   assign taken     = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign crc_next  = in_header ? crc_ff : crc_byte_update(crc_ff, item.data_byte, poly);
   assign computed  = crc_next ^ CRC_XOROUT;

   always_comb begin
      captured_next = captured_ff;
      if (in_header) begin
         captured_next[8*pos_ff[1:0] +: BYTE_W] = item.data_byte;
      end
   end

   always_comb begin
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      captured_in  = captured_ff;
      page_in      = page_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      r_page_in    = r_page_ff;
      r_kind_in    = r_kind_ff;
      r_stored_in  = r_stored_ff;
      r_calc_in    = r_calc_ff;
      r_ok_in      = r_ok_ff;
      r_bytes_in   = r_bytes_ff;
      if (take) begin
         crc_in      = crc_next;
         pos_in      = taken[POS_W-1:0];
         captured_in = captured_next;
         if (page_full) begin
            rsp_valid_in = 1'b1;
            r_page_in    = page_ff;
            r_kind_in    = KIND_FULL;
            r_stored_in  = captured_next;
            r_calc_in    = computed;
            r_ok_in      = (captured_next == computed);
            r_bytes_in   = FULL_BYTES;
            page_in      = page_ff + 32'd1;
         end else if (item.end_of_section) begin
            rsp_valid_in = 1'b1;
            r_page_in    = page_ff;
            r_kind_in    = KIND_PARTIAL;
            r_stored_in  = '0;
            r_calc_in    = '0;
            r_ok_in      = 1'b0;
            r_bytes_in   = COUNT_W'(taken);
         end
         if (page_full || item.end_of_section) begin
            crc_in      = CRC_INIT;
            pos_in      = '0;
            captured_in = '0;
         end
         if (item.end_of_section) begin
            page_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         pos_ff       <= '0;
         captured_ff  <= '0;
         page_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         captured_ff  <= captured_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_page_ff   <= r_page_in;
      r_kind_ff   <= r_kind_in;
      r_stored_ff <= r_stored_in;
      r_calc_ff   <= r_calc_in;
      r_ok_ff     <= r_ok_in;
      r_bytes_ff  <= r_bytes_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.page_number  = r_page_ff;
   assign rsp_chan.page_kind    = r_kind_ff;
   assign rsp_chan.stored_crc   = r_stored_ff;
   assign rsp_chan.computed_crc = r_calc_ff;
   assign rsp_chan.crc_ok       = r_ok_ff;
   assign rsp_chan.page_bytes   = r_bytes_ff;

endmodule

>>> design/crc32_page_validator_top.sv
// CRC-32 page validator.
// req_chan: one section byte per transfer, with end_of_section on the last byte.
//    Bytes are cut into PAGE_BYTES pages; the first four bytes of a page are the
//    stored CRC (little-endian), the rest are payload for a reflected CRC-32.
// rsp_chan: one transfer per finished page (full page, page_kind 0, with stored
//    and computed CRC and crc_ok) or per trailing partial page (page_kind 1,
//    CRC fields zero, page_bytes gives its length). Other bytes give no transfer.
// csr_chan: writes crc_polynomial; always ready. Write only while the block is
//    idle; a new value applies from the next byte processed.
// Result path: a byte that completes a page passes the input register and then
//    the result register before its result is valid on rsp_chan. Throughput:
//    one byte per cycle while rsp_chan does not stall, set by the single CRC byte
//    update between the input register and the result register.
// Stall: while a result waits on rsp_chan, one more byte is held in the input
//    register and req_chan ready drops only when both registers are full.
// Reset: CRC state back to all ones, page counter and byte position to zero,
//    polynomial to 0xEDB88320, both channels emptied. end_of_section also
//    returns the page state and counter to zero after its report.
module crc32_page_validator_top import cpv_pkg::*; #(
   parameter int unsigned PAGE_BYTES = 1024
) (
   input logic       clock,
   input logic       reset,
   cpv_req_if.sink   req_chan,
   cpv_rsp_if.source rsp_chan,
   cpv_csr_if.sink   csr_chan
);

   logic [CRC_W-1:0] poly_ff, poly_in;
   logic             item_valid;
   byte_item_type    item;
   logic             take;

   // Polynomial register: accept a write on every cycle.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      poly_in = poly_ff;
      if (csr_chan.valid) begin
         poly_in = csr_chan.crc_polynomial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
      end else begin
         poly_ff <= poly_in;
      end
   end

   // Hold the incoming byte until the page engine can take it.
   cpv_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // Advance the CRC and page state; register the page report.
   cpv_page_engine #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .poly       (poly_ff),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> design/cpv_checker.sv
module cpv_checker import cpv_pkg::*; #(
   parameter int unsigned PAGE_BYTES = 1024
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [CRC_W-1:0]   rsp_page_number,
   input logic               rsp_page_kind,
   input logic [CRC_W-1:0]   rsp_stored_crc,
   input logic [CRC_W-1:0]   rsp_computed_crc,
   input logic               rsp_crc_ok,
   input logic [COUNT_W-1:0] rsp_page_bytes
);

   localparam logic [COUNT_W-1:0] FULL_BYTES = COUNT_W'(PAGE_BYTES);

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_page_number) && $stable(rsp_page_kind)
         && $stable(rsp_stored_crc) && $stable(rsp_computed_crc)
         && $stable(rsp_page_bytes))
      else $error("result changed while stalled");

   // Full page: fixed length, match flag agrees with the CRC fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_kind == KIND_FULL |->
         rsp_page_bytes == FULL_BYTES
         && rsp_crc_ok == (rsp_stored_crc == rsp_computed_crc))
      else $error("full page report inconsistent");

   // Partial page: CRC fields zero, crc_ok low, length not zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_kind == KIND_PARTIAL |->
         rsp_stored_crc == '0 && rsp_computed_crc == '0 && !rsp_crc_ok
         && rsp_page_bytes != '0)
      else $error("partial page report inconsistent");

   // No result straight out of reset, and none unless a byte moved or req_chan stalled before.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2)
         || $past(req_valid && req_ready, 3) || $past(!req_ready, 2))
      else $error("result without a byte transfer");

endmodule

bind crc32_page_validator_top cpv_checker #(
   .PAGE_BYTES (PAGE_BYTES)
) u_cpv_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_page_number  (rsp_chan.page_number),
   .rsp_page_kind    (rsp_chan.page_kind),
   .rsp_stored_crc   (rsp_chan.stored_crc),
   .rsp_computed_crc (rsp_chan.computed_crc),
   .rsp_crc_ok       (rsp_chan.crc_ok),
   .rsp_page_bytes   (rsp_chan.page_bytes)
);

>>> bench/tb_crc32_page_validator_top.sv
module tb_crc32_page_validator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cpv_pkg::*;

   localparam int unsigned PAGE_LEN        = 1024;
   localparam int unsigned PAYLOAD_LEN     = PAGE_LEN - HEADER_BYTES;
   localparam int unsigned RESET_CYCLES    = 11;
   localparam int unsigned DRAIN_CYCLES    = 4;     // lets a byte pass the input and result registers
   localparam int unsigned QUIET_LIMIT     = 4000;  // cycles without any transfer
   localparam int unsigned SHORT_BYTES     = 24;    // short-section bytes per phase
   localparam int unsigned SHORT_MAX       = 12;    // longest short section
   localparam int unsigned FULL_TAIL_MAX   = 40;    // longest tail after the full page
   localparam int unsigned MAX_REPORTS     = 10;
   localparam int unsigned HEAVY_IDLE_PCT  = 87;
   localparam int unsigned LIGHT_IDLE_PCT  = 16;
   localparam int unsigned N_PHASES        = 5;
   localparam int unsigned N_ROWS          = 8;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [CRC_W-1:0]   page_number;
      logic               page_kind;
      logic [CRC_W-1:0]   stored_crc;
      logic [CRC_W-1:0]   computed_crc;
      logic               crc_ok;
      logic [COUNT_W-1:0] page_bytes;
   } page_report_type;

   // One line of the directed stimulus: fill byte repeated reps times, section
   // end on the last repeat when last is set, and an optional hand-written report for that byte.
   typedef struct {
      logic [BYTE_W-1:0] fill;
      int unsigned       reps;
      logic              last;
      bit                literal;
      page_report_type   want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5ns clock = ~clock;

   cpv_req_if req_bus ();
   cpv_rsp_if rsp_bus ();
   cpv_csr_if csr_bus ();

   crc32_page_validator_top #(.PAGE_BYTES(PAGE_LEN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state: mirrors the page machine inside the block.
   logic [CRC_W-1:0] model_poly;
   logic [CRC_W-1:0] model_crc;
   logic [CRC_W-1:0] model_stored;
   logic [CRC_W-1:0] model_page;
   int unsigned      model_pos;

   page_report_type expected_pages [$];

   int unsigned send_idle_pct      = 0;
   int unsigned recv_stall_pct     = 0;
   int unsigned mismatch_count     = 0;
   int unsigned quiet_cycles       = 0;
   int unsigned bytes_sent         = 0;
   int unsigned sections_sent      = 0;
   int unsigned full_pages_seen    = 0;
   int unsigned good_pages_seen    = 0;
   int unsigned partial_pages_seen = 0;

   // Reflected CRC over one byte, LSB first, one shift per bit.
   function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0]  crc,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [CRC_W-1:0]  poly);
      logic [CRC_W-1:0] r;
      r = crc ^ CRC_W'(b);
      repeat (BYTE_W) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
      return r;
   endfunction

   function automatic void open_page();
      model_crc    = CRC_INIT;
      model_pos    = 0;
      model_stored = '0;
   endfunction

   function automatic page_report_type partial_page(input logic [CRC_W-1:0] page,
                                                    input int unsigned      count);
      page_report_type r;
      r             = '0;
      r.page_number = page;
      r.page_kind   = KIND_PARTIAL;
      r.page_bytes  = COUNT_W'(count);
      return r;
   endfunction

   // Advance the page machine by one byte; return 1 when that byte closes a page.
   function automatic bit predict_page(input logic [BYTE_W-1:0] b, input logic last,
                                       output page_report_type rep);
      bit closed;
      closed = 1'b0;
      rep    = '0;
      // Header bytes build the stored CRC little-endian; the rest feed the CRC.
      if (model_pos < HEADER_BYTES) begin
         model_stored |= CRC_W'(b) << (BYTE_W * model_pos);
      end else begin
         model_crc = crc_shift_byte(model_crc, b, model_poly);
      end
      if (model_pos + 1 >= PAGE_LEN) begin
         rep.page_number  = model_page;
         rep.page_kind    = KIND_FULL;
         rep.stored_crc   = model_stored;
         rep.computed_crc = model_crc ^ CRC_XOROUT;
         rep.crc_ok       = (rep.stored_crc == rep.computed_crc);
         rep.page_bytes   = COUNT_W'(PAGE_LEN);
         closed           = 1'b1;
         model_page       = model_page + 1;
         open_page();
      end else if (last) begin
         rep    = partial_page(model_page, model_pos + 1);
         closed = 1'b1;
         open_page();
      end else begin
         model_pos++;
      end
      // Section end always restarts at page 0.
      if (last) begin
         open_page();
         model_page = '0;
      end
      return closed;
   endfunction

   function automatic string show(input page_report_type r);
      return $sformatf("page %0d kind %0d stored %h computed %h ok %0d bytes %0d",
                       r.page_number, r.page_kind, r.stored_crc, r.computed_crc,
                       r.crc_ok, r.page_bytes);
   endfunction

   // Offer one byte at the falling edge, idling at random first; hold it until
   // the transfer, then book the page report it closes, if any.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input bit use_literal, input page_report_type literal);
      page_report_type rep;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= b;
      req_bus.end_of_section <= last;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      if (predict_page(b, last, rep)) begin
         expected_pages.insert(expected_pages.size(), use_literal ? literal : rep);
      end
   endtask

   // Build a section of well-formed pages (stored CRC matches the payload under
   // the current polynomial, one in five broken by a flipped bit), then a tail.
   task automatic send_section(input int unsigned pages, input int unsigned tail);
      logic [BYTE_W-1:0] stream [$];
      logic [BYTE_W-1:0] payload [PAYLOAD_LEN];
      logic [CRC_W-1:0]  crc;
      for (int unsigned p = 0; p < pages; p++) begin
         crc = CRC_INIT;
         foreach (payload[i]) begin
            payload[i] = BYTE_W'($urandom);
            crc        = crc_shift_byte(crc, payload[i], model_poly);
         end
         crc ^= CRC_XOROUT;
         if ($urandom_range(4) == 0) begin
            crc[$urandom_range(CRC_W-1)] ^= 1'b1;
         end
         for (int unsigned k = 0; k < HEADER_BYTES; k++) begin
            stream.insert(stream.size(), crc[BYTE_W*k +: BYTE_W]);
         end
         foreach (payload[i]) stream.insert(stream.size(), payload[i]);
      end
      repeat (tail) stream.insert(stream.size(), BYTE_W'($urandom));
      foreach (stream[i]) begin
         send_byte(stream[i], i == stream.size() - 1, 1'b0, '0);
      end
      sections_sent++;
   endtask

   // Drop valid, wait for every booked report, then let the pipeline settle
   // so a byte that closes no page is also out of the block.
   task automatic wait_for_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_pages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_poly(input logic [CRC_W-1:0] value);
      @(negedge clock);
      csr_bus.valid          <= 1'b1;
      csr_bus.crc_polynomial <= value;
      do @(posedge clock); while (!csr_bus.ready);
      model_poly = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Receiver: decide backpressure at each falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result checker: compare each transfer on the result channel against the
   // oldest booked report, field by field.
   always @(posedge clock) begin
      page_report_type got;
      page_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.page_number  = rsp_bus.page_number;
         got.page_kind    = rsp_bus.page_kind;
         got.stored_crc   = rsp_bus.stored_crc;
         got.computed_crc = rsp_bus.computed_crc;
         got.crc_ok       = rsp_bus.crc_ok;
         got.page_bytes   = rsp_bus.page_bytes;
         if (got.page_kind === KIND_PARTIAL) begin
            partial_pages_seen++;
         end else begin
            full_pages_seen++;
            if (got.crc_ok === 1'b1) good_pages_seen++;
         end
         if (expected_pages.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("[%0t] unexpected page report: %s", $realtime, show(got));
            end
         end else begin
            want = expected_pages.pop_front();
            if (got.page_number !== want.page_number || got.page_kind !== want.page_kind ||
                got.stored_crc !== want.stored_crc ||
                got.computed_crc !== want.computed_crc ||
                got.crc_ok !== want.crc_ok || got.page_bytes !== want.page_bytes) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("[%0t] page report mismatch", $realtime);
                  $display("   expected %s", show(want));
                  $display("   actual   %s", show(got));
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which no channel moves a transfer.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      directed_row_type rows [N_ROWS];
      idle_mode_type    modes [N_PHASES];
      logic [CRC_W-1:0] polys [N_PHASES];
      int unsigned      phase_start;
      int unsigned      tail;

      // Known values on every input from time zero.
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.end_of_section = 1'b0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.crc_polynomial = '0;

      model_poly = POLY_RESET;
      model_page = '0;
      open_page();

      // Hold reset, release it on a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset polynomial, no idling. Rows with a written-out
      // report are partial pages whose fields follow from the byte count.
      rows = '{
         '{8'h00, 1,          1'b1, 1'b1, partial_page(0, 1)},  // single-byte section
         '{8'hFF, 1,          1'b1, 1'b1, partial_page(0, 1)},
         '{8'hA5, 1,          1'b0, 1'b0, '0},
         '{8'h5A, 1,          1'b0, 1'b0, '0},
         '{8'h3C, 1,          1'b1, 1'b1, partial_page(0, 3)},  // ends inside the header
         '{8'h01, 4,          1'b0, 1'b0, '0},
         '{8'h80, 1,          1'b1, 1'b1, partial_page(0, 5)},
         '{8'h10, 3,          1'b0, 1'b0, '0}                   // leave a page open
      };
      foreach (rows[r]) begin
         for (int unsigned k = 0; k < rows[r].reps; k++) begin
            send_byte(rows[r].fill, rows[r].last && (k == rows[r].reps - 1),
                      rows[r].literal && (k == rows[r].reps - 1), rows[r].want);
         end
      end

      // Random phases: each switches polynomial and idling pattern. The open
      // page left behind by the previous phase picks up the new polynomial.
      modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_BOTH};
      polys = '{32'h0000_0000, 32'hFFFF_FFFF, CRC_W'($urandom), 32'h82F6_3B78, POLY_RESET};
      foreach (modes[ph]) begin
         wait_for_idle();
         write_poly(polys[ph]);
         case (modes[ph])
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct  = HEAVY_IDLE_PCT;
               recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct  = 0;
               recv_stall_pct = HEAVY_IDLE_PCT;
            end
            default: begin
               send_idle_pct  = LIGHT_IDLE_PCT;
               recv_stall_pct = LIGHT_IDLE_PCT;
            end
         endcase

         // Short sections: partial pages of small lengths.
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < SHORT_BYTES) begin
            send_section(0, $urandom_range(1, SHORT_MAX));
         end

         // Last phase: one section with a well-formed page; the tail may be
         // empty, so the section can end right on the page boundary.
         if (ph == N_PHASES - 1) begin
            case ($urandom_range(2))
               0:       tail = 0;
               1:       tail = $urandom_range(1, HEADER_BYTES - 1);
               default: tail = $urandom_range(1, FULL_TAIL_MAX);
            endcase
            send_section(1, tail);
         end

         repeat ($urandom_range(0, 5)) send_byte(BYTE_W'($urandom), 1'b0, 1'b0, '0);
      end

      wait_for_idle();

      $display("Sent %0d bytes in %0d random sections over %0d polynomial/idle phases",
               bytes_sent, sections_sent, N_PHASES);
      $display("Checked %0d full pages (%0d with matching CRC) and %0d partial pages",
               full_pages_seen, good_pages_seen, partial_pages_seen);
      if (mismatch_count == 0 && expected_pages.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d bad page reports, %0d still outstanding",
                  mismatch_count, expected_pages.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
